// File: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and helpers shared by the frame deframer and its channels.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned LEN_W   = 64;
    localparam int unsigned LIMIT_W = 32;

    localparam logic [31:0] LIMIT_RESET = 32'd1048576;

    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam logic [1:0] ACT_TEXT   = 2'd0;
    localparam logic [1:0] ACT_PONG   = 2'd1;
    localparam logic [1:0] ACT_CLOSE  = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic [1:0] frame_action;
        logic       frame_last;
    } result_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] max_payload_len;
    } cfg_item_t;

    function automatic logic [1:0] action_of(input logic [3:0] opc);
        logic [1:0] act;
        case (opc)
            OPC_TEXT:  act = ACT_TEXT;
            OPC_PING:  act = ACT_PONG;
            OPC_CLOSE: act = ACT_CLOSE;
            default:   act = ACT_IGNORE;
        endcase
        return act;
    endfunction

endpackage

// File: hdl/wsd_stream_if.sv
// ----------------------------------------------------------------------------
// wsd_stream_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface wsd_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// File: hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame parser of one connection, one received byte per
// transaction.
//
// Channels: rx (sink, rx_byte), res (source, one result per byte that ends a
// frame or carries a delivered payload byte), cfg (sink, max_payload_len).
// Each byte is captured in an input register, parsed by the header/payload
// state update, and its result lands in an output register, from which it is
// presented on res. One byte per cycle is accepted while res takes results;
// the per-byte rate is set by the single state update stage, whose widest path
// is the 64-bit length decrement and limit compare. When res stalls, the
// output register holds and the input register still takes a byte if it is
// empty; with both full, rx ready drops. Reset clears the parser to the first
// header byte, the limit to 1048576 and empties both registers. After a close
// frame completes, all bytes are consumed with no result until reset. cfg is
// always ready.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    wsd_stream_if.sink   rx,
    wsd_stream_if.source res,
    wsd_stream_if.sink   cfg
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HEAD0   = 3'd0;
    localparam logic [2:0] PH_HEAD1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [LIMIT_W-1:0] limit_reg;

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;

    logic               out_valid_reg, out_valid_next;
    result_t            out_payload_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic               mask_on_reg, mask_on_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [31:0]        mask_word_reg, mask_word_next;
    logic [1:0]         mask_pos_reg, mask_pos_next;
    logic               deliver_reg, deliver_next;
    logic               closed_reg, closed_next;

    logic               proceed;
    logic               res_valid;
    result_t            res_item;
    logic               hdr_done;
    logic [LEN_W-1:0]   hdr_len;
    logic               frame_end;
    logic [LEN_W-1:0]   ext_len;
    logic [LEN_W-1:0]   rem_dec;
    logic [7:0]         key;

    assign proceed   = !out_valid_reg || res.ready;
    assign rx.ready  = !in_valid_reg || proceed;
    assign cfg.ready = 1'b1;

    assign res.valid   = out_valid_reg;
    assign res.payload = out_payload_reg;

    assign ext_len = {rem_reg[LEN_W-9:0], in_byte_reg};
    assign rem_dec = rem_reg - LEN_W'(1);

    always_comb
    begin
        case (mask_pos_reg)
            2'd0:    key = mask_word_reg[31:24];
            2'd1:    key = mask_word_reg[23:16];
            2'd2:    key = mask_word_reg[15:8];
            default: key = mask_word_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        mask_on_next   = mask_on_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        mask_word_next = mask_word_reg;
        mask_pos_next  = mask_pos_reg;
        deliver_next   = deliver_reg;
        closed_next    = closed_reg;
        res_valid      = 1'b0;
        res_item.payload_byte = 8'h00;
        res_item.has_data     = 1'b0;
        res_item.frame_opcode = opcode_reg;
        res_item.frame_action = action_of(opcode_reg);
        res_item.frame_last   = 1'b0;
        hdr_done  = 1'b0;
        hdr_len   = rem_reg;
        frame_end = 1'b0;

        if (in_valid_reg && proceed && !closed_reg)
        begin
            case (phase_reg)
                PH_HEAD1:
                begin
                    mask_on_next   = in_byte_reg[7];
                    mask_word_next = 32'h0;
                    mask_pos_next  = 2'd0;
                    rem_next       = '0;
                    if (in_byte_reg[6:0] == LEN7_EXT16 || in_byte_reg[6:0] == LEN7_EXT64)
                    begin
                        cnt_next   = (in_byte_reg[6:0] == LEN7_EXT16) ? EXT16_BYTES
                                                                      : EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (in_byte_reg[7])
                    begin
                        rem_next   = {57'd0, in_byte_reg[6:0]};
                        cnt_next   = MASK_BYTES;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                        hdr_len  = {57'd0, in_byte_reg[6:0]};
                    end
                end
                PH_EXTLEN:
                begin
                    rem_next = ext_len;
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        if (mask_on_reg)
                        begin
                            cnt_next   = MASK_BYTES;
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            hdr_done = 1'b1;
                            hdr_len  = ext_len;
                        end
                    end
                end
                PH_MASK:
                begin
                    mask_word_next = {mask_word_reg[23:0], in_byte_reg};
                    cnt_next       = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        hdr_done = 1'b1;
                        hdr_len  = rem_reg;
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_pos_next = mask_pos_reg + 2'd1;
                    rem_next      = rem_dec;
                    if (deliver_reg)
                    begin
                        res_valid             = 1'b1;
                        res_item.payload_byte = in_byte_reg ^ key;
                        res_item.has_data     = 1'b1;
                        res_item.frame_last   = (rem_dec == '0);
                        frame_end             = (rem_dec == '0);
                    end
                    else if (rem_dec == '0)
                    begin
                        res_valid           = 1'b1;
                        res_item.frame_last = 1'b1;
                        frame_end           = 1'b1;
                    end
                end
                default:
                begin
                    opcode_next = in_byte_reg[3:0];
                    phase_next  = PH_HEAD1;
                end
            endcase

            if (hdr_done)
            begin
                rem_next     = hdr_len;
                deliver_next = (hdr_len != '0) && (hdr_len < {32'd0, limit_reg});
                if (hdr_len == '0)
                begin
                    res_valid           = 1'b1;
                    res_item.frame_last = 1'b1;
                    frame_end           = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end

            if (frame_end)
            begin
                phase_next = PH_HEAD0;
                if (opcode_reg == OPC_CLOSE)
                begin
                    closed_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = proceed ? res_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEAD0;
            opcode_reg    <= 4'h0;
            mask_on_reg   <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= 4'd0;
            mask_word_reg <= 32'h0;
            mask_pos_reg  <= 2'd0;
            deliver_reg   <= 1'b0;
            closed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                limit_reg <= cfg.payload.max_payload_len;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            mask_on_reg   <= mask_on_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            mask_word_reg <= mask_word_next;
            mask_pos_reg  <= mask_pos_next;
            deliver_reg   <= deliver_next;
            closed_reg    <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.payload.rx_byte;
        end
        if (proceed)
        begin
            out_payload_reg <= res_item;
        end
    end

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("connection reopened without reset");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_payload_reg.has_data) |-> out_payload_reg.payload_byte == 8'h00)
        else $error("data-less result carries a nonzero byte");

    a_action_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_payload_reg.frame_action == action_of(out_payload_reg.frame_opcode))
        else $error("result action does not match its opcode");

    a_extlen_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTLEN || phase_reg == PH_MASK) |-> cnt_reg != 4'd0)
        else $error("field byte count exhausted inside a header field");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a captured byte");

endmodule

// File: bench/tb_websocket_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking bench for the receive-side frame deframer. Frames are built
// byte by byte, with random flag bits, all three length encodings, masked and
// unmasked payloads, and payload lengths around the delivery limit. Each byte
// accepted on rx updates a model of the parser in the scoreboard, which queues
// the expected result. Every result taken from res is checked field by field
// against the oldest queued one. The limit is rewritten between phases and in
// the middle of frames. rx sees random gaps and res random stalls. The run ends
// with either a completed close frame or a frame with a huge 64-bit length.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int DRAIN_CYCLES    = 6;
    localparam int TAIL_CYCLES     = 10;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int PHASE_BYTES     = 180;
    localparam int PHASE_COUNT     = 7;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam int END_CLOSE = 0;
    localparam int END_HUGE  = 1;

    typedef enum logic [2:0] {
        AT_HEAD0,
        AT_HEAD1,
        AT_EXTLEN,
        AT_MASK,
        AT_PAYLOAD
    } parse_step_t;

    class deframe_scoreboard;
        logic [31:0] limit;
        parse_step_t step;
        logic [3:0]  opc;
        logic        masked;
        logic [63:0] remaining;
        logic [3:0]  field_left;
        logic [31:0] key;
        logic [1:0]  key_pos;
        logic        deliver;
        logic        closed;
        result_t     expected_results[$];
        int          errors;
        int          data_results;
        int          frame_ends;

        function new();
            limit        = LIMIT_RESET;
            step         = AT_HEAD0;
            opc          = '0;
            masked       = 1'b0;
            remaining    = '0;
            field_left   = '0;
            key          = '0;
            key_pos      = '0;
            deliver      = 1'b0;
            closed       = 1'b0;
            errors       = 0;
            data_results = 0;
            frame_ends   = 0;
        endfunction

        function logic [1:0] action_for(logic [3:0] code);
            if (code == OPC_TEXT)
                return ACT_TEXT;
            if (code == OPC_PING)
                return ACT_PONG;
            if (code == OPC_CLOSE)
                return ACT_CLOSE;
            return ACT_IGNORE;
        endfunction

        // a last result always ends the frame
        function void queue_result(logic [7:0] data, logic has, logic last);
            result_t r;
            r.payload_byte = data;
            r.has_data     = has;
            r.frame_opcode = opc;
            r.frame_action = action_for(opc);
            r.frame_last   = last;
            expected_results = {expected_results, r};
            if (has)
                data_results++;
            if (last)
            begin
                frame_ends++;
                if (opc == OPC_CLOSE)
                    closed = 1'b1;
                step = AT_HEAD0;
            end
        endfunction

        function void header_done();
            deliver = (remaining != 64'd0) && (remaining < {32'd0, limit});
            if (remaining == 64'd0)
                queue_result(8'h00, 1'b0, 1'b1);
            else
                step = AT_PAYLOAD;
        endfunction

        function void length_done();
            if (masked)
            begin
                field_left = MASK_BYTES;
                step       = AT_MASK;
            end
            else
                header_done();
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] key_byte;
            logic       last;
            if (closed)
                return;
            case (step)
                AT_HEAD1:
                begin
                    masked    = b[7];
                    key       = '0;
                    key_pos   = '0;
                    remaining = '0;
                    if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64)
                    begin
                        field_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        step       = AT_EXTLEN;
                    end
                    else
                    begin
                        remaining = {57'd0, b[6:0]};
                        length_done();
                    end
                end
                AT_EXTLEN:
                begin
                    remaining  = {remaining[55:0], b};
                    field_left = field_left - 4'd1;
                    if (field_left == 4'd0)
                        length_done();
                end
                AT_MASK:
                begin
                    key        = {key[23:0], b};
                    field_left = field_left - 4'd1;
                    if (field_left == 4'd0)
                        header_done();
                end
                AT_PAYLOAD:
                begin
                    key_byte  = key[8 * (3 - int'(key_pos)) +: 8];
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 64'd1;
                    last      = (remaining == 64'd0);
                    if (deliver)
                        queue_result(b ^ key_byte, 1'b1, last);
                    else if (last)
                        queue_result(8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                    opc  = b[3:0];
                    step = AT_HEAD1;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: payload_byte %0h frame_opcode %0h frame_last %0b",
                       got.payload_byte, got.frame_opcode, got.frame_last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("has_data", want.has_data, got.has_data);
            compare_field("frame_opcode", want.frame_opcode, got.frame_opcode);
            compare_field("frame_action", want.frame_action, got.frame_action);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wsd_stream_if #(.payload_t(rx_item_t))  rx_if ();
    wsd_stream_if #(.payload_t(result_t))   res_if ();
    wsd_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

    websocket_frame_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    deframe_scoreboard sb = new();

    logic [7:0] frame_q[$];
    int         bytes_sent   = 0;
    int         frames_built = 0;
    int         limit_writes = 0;
    int         quiet_cycles = 0;
    bit         gaps_on      = 1'b1;
    bit         stalls_on    = 1'b1;
    int         end_kind;

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // mostly short pauses, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_limit();
        int r;
        r = $urandom_range(0, 3);
        case (r)
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        frame_q = {frame_q, b};
    endfunction

    function automatic void build_frame(input logic [3:0] opc, input logic masked,
                                        input logic [31:0] key, input logic [63:0] len,
                                        input int form, input int payload_n);
        logic [3:0] flags;
        flags = 4'($urandom);
        frame_q.delete();
        add_byte({flags, opc});
        case (form)
            FORM_SHORT:
                add_byte({masked, len[6:0]});
            FORM_EXT16:
            begin
                add_byte({masked, LEN7_EXT16});
                add_byte(len[15:8]);
                add_byte(len[7:0]);
            end
            default:
            begin
                add_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    add_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                add_byte(key[8 * i +: 8]);
        for (int i = 0; i < payload_n; i++)
            add_byte(8'($urandom));
        frames_built++;
    endfunction

    function automatic void build_random_frame();
        logic [3:0]  opc;
        logic        masked;
        logic [31:0] key;
        logic [63:0] len;
        int          form;
        int          r;
        int          near;
        r   = $urandom_range(0, 99);
        opc = (r < 40) ? OPC_TEXT : (r < 65) ? OPC_PING : 4'($urandom);
        if (opc == OPC_CLOSE)
            opc = 4'h0;
        masked = ($urandom_range(0, 99) < 70);
        r   = $urandom_range(0, 99);
        key = (r < 8) ? 32'h0 : (r < 16) ? 32'hFFFF_FFFF : 32'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55)
            len = 64'($urandom_range(0, 12));
        else if (r < 70)
        begin
            // straddle the limit when it is small enough to reach
            if (sb.limit <= 32'd200)
            begin
                near = int'(sb.limit) - 1 + int'($urandom_range(0, 2));
                len  = (near < 0) ? 64'd0 : 64'(near);
            end
            else
                len = 64'($urandom_range(0, 12));
        end
        else if (r < 74)
            len = 64'($urandom_range(100, 125));
        else if (r < 84)
            len = 64'($urandom_range(0, 140));
        else if (r < 99)
            len = 64'($urandom_range(0, 24));
        else
            len = 64'($urandom_range(150, 300));
        if (len > 64'd125)
            form = ($urandom_range(0, 3) == 0) ? FORM_EXT64 : FORM_EXT16;
        else
        begin
            r    = $urandom_range(0, 99);
            form = (r < 70) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
        end
        build_frame(opc, masked, key, len, form, int'(len));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? pick_pause() : 0;
        if (gap > 0)
        begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid          = 1'b1;
        rx_if.payload.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_range(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            push_byte(frame_q[i]);
    endtask

    // bytes that give no result may still be in flight after the last one
    task automatic settle();
        rx_if.valid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        settle();
        cfg_if.valid                   = 1'b1;
        cfg_if.payload.max_payload_len = v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.limit = v;
        limit_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] lim, input bit gaps, input bit stalls);
        int start;
        int cut;
        write_limit(lim);
        gaps_on   = gaps;
        stalls_on = stalls;
        start     = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            build_random_frame();
            if (frame_q.size() > 1 && $urandom_range(0, 99) < 8)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                send_range(0, cut);
                write_limit(pick_limit());
                send_range(cut, frame_q.size());
            end
            else
                send_range(0, frame_q.size());
        end
    endtask

    initial
    begin : sink_proc
        int stall_left;
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && stalls_on && rst_n)
                stall_left = pick_pause();
            if (stall_left > 0)
            begin
                res_if.ready = 1'b0;
                stall_left--;
            end
            else
                res_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.payload);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] phase_limits[PHASE_COUNT];
        logic [63:0] huge_len;
        bit          gaps;
        bit          stalls;

        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames under the reset limit
        build_frame(OPC_TEXT, 1'b0, 32'h0, 64'd0, FORM_SHORT, 0);
        send_range(0, frame_q.size());
        build_frame(OPC_TEXT, 1'b1, 32'hA5C3_0F96, 64'd3, FORM_SHORT, 3);
        send_range(0, frame_q.size());
        build_frame(OPC_PING, 1'b0, 32'h0, 64'd1, FORM_SHORT, 1);
        send_range(0, frame_q.size());
        build_frame(4'hF, 1'b1, 32'hFFFF_FFFF, 64'd2, FORM_SHORT, 2);
        send_range(0, frame_q.size());
        build_frame(4'h0, 1'b1, 32'h0, 64'd1, FORM_EXT16, 1);
        send_range(0, frame_q.size());
        build_frame(OPC_PING, 1'b1, $urandom, 64'd0, FORM_EXT64, 0);
        send_range(0, frame_q.size());

        // just below and at the limit
        write_limit(32'd3);
        build_frame(OPC_TEXT, 1'b0, 32'h0, 64'd2, FORM_SHORT, 2);
        send_range(0, frame_q.size());
        build_frame(OPC_TEXT, 1'b1, $urandom, 64'd3, FORM_SHORT, 3);
        send_range(0, frame_q.size());

        // delivery is decided when the header completes
        write_limit(32'd100);
        build_frame(OPC_TEXT, 1'b1, $urandom, 64'd4, FORM_SHORT, 4);
        send_range(0, 6);
        write_limit(32'd1);
        send_range(6, frame_q.size());
        build_frame(OPC_PING, 1'b0, 32'h0, 64'd3, FORM_SHORT, 3);
        send_range(0, 2);
        write_limit(32'd100);
        send_range(2, frame_q.size());

        phase_limits[0] = 32'hFFFF_FFFF;
        phase_limits[1] = 32'd1;
        phase_limits[2] = $urandom_range(2, 10);
        phase_limits[3] = 32'd0;
        phase_limits[4] = $urandom_range(11, 140);
        phase_limits[5] = $urandom;
        phase_limits[6] = LIMIT_RESET;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
            begin
                gaps   = 1'b1;
                stalls = 1'b1;
            end
            else if (p == 1)
            begin
                gaps   = 1'b0;
                stalls = 1'b0;
            end
            else
            begin
                gaps   = ($urandom_range(0, 3) != 0);
                stalls = ($urandom_range(0, 3) != 0);
            end
            run_phase(phase_limits[p], gaps, stalls);
        end

        // both endings are terminal, so each run takes one of them
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        end_kind  = $urandom_range(END_CLOSE, END_HUGE);
        if (end_kind == END_CLOSE)
        begin
            build_frame(OPC_CLOSE, 1'($urandom), $urandom, 64'($urandom_range(0, 10)),
                        FORM_SHORT, 0);
            for (int i = 0; i < int'(frame_q[1][6:0]); i++)
                add_byte(8'($urandom));
            send_range(0, frame_q.size());
            for (int i = 0; i < 30; i++)
                push_byte(8'($urandom));
        end
        else
        begin
            huge_len = {1'b1, 31'($urandom), 32'($urandom)};
            build_frame(OPC_TEXT, 1'b1, $urandom, huge_len, FORM_EXT64, 24);
            send_range(0, frame_q.size());
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.errors++;
        end

        $display("Covered %0d bytes in %0d frames with %0d limit writes:",
                 bytes_sent, frames_built, limit_writes);
        $display("%0d payload bytes, %0d frame ends, final frame: %s",
                 sb.data_results, sb.frame_ends, (end_kind == END_CLOSE) ?
                 "close, then discarded bytes" : "64-bit length with top bit set");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/wsd_pkg.sv
hdl/wsd_stream_if.sv
hdl/websocket_frame_deframer.sv
bench/tb_websocket_frame_deframer.sv
